// ===== sv/uer_pkg.sv =====
// Shared types and constants for the ultrasonic echo ranger.
package uer_pkg;

  localparam int unsigned TRIG_W  = 10;
  localparam int unsigned TOUT_W  = 20;
  localparam int unsigned DIV_W   = 6;
  localparam int unsigned DIST_W  = 14;
  localparam int unsigned PULSE_W = 20;
  localparam int unsigned CFG_W   = 20;
  localparam int unsigned IDX_W   = 3;

  localparam logic [PULSE_W-1:0] PULSE_MAX = {PULSE_W{1'b1}};
  localparam logic [DIST_W-1:0]  DIST_MAX  = {DIST_W{1'b1}};

  // Register indexes on the configuration port.
  localparam logic [IDX_W-1:0] REG_TRIGGER_US   = 3'd0;
  localparam logic [IDX_W-1:0] REG_TIMEOUT_US   = 3'd1;
  localparam logic [IDX_W-1:0] REG_US_PER_CM    = 3'd2;
  localparam logic [IDX_W-1:0] REG_MAX_DISTANCE = 3'd3;

  // Reset values of the registers.
  localparam logic [TRIG_W-1:0] TRIGGER_US_RST   = 10'd16;
  localparam logic [TOUT_W-1:0] TIMEOUT_US_RST   = 20'd500000;
  localparam logic [DIV_W-1:0]  US_PER_CM_RST    = 6'd58;
  localparam logic [DIST_W-1:0] MAX_DISTANCE_RST = 14'd500;

  // Result status codes.
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_TRIG_STUCK = 3'd1;
  localparam logic [2:0] ST_TRIG_NOHI  = 3'd2;
  localparam logic [2:0] ST_TRIG_NOLO  = 3'd3;
  localparam logic [2:0] ST_ECHO_EARLY = 3'd4;
  localparam logic [2:0] ST_NO_RISE    = 3'd5;
  localparam logic [2:0] ST_NO_FALL    = 3'd6;
  localparam logic [2:0] ST_TOO_FAR    = 3'd7;

  typedef struct packed {
    logic               trig_drive;
    logic               busy;
    logic               done;
    logic [2:0]         status;
    logic [PULSE_W-1:0] pulse_us;
    logic [DIST_W-1:0]  distance_cm;
  } res_t;

  // Echo counter control from the sequencer.
  typedef struct packed {
    logic clear;
    logic count;
  } echo_ctl_t;

endpackage

// ===== sv/uer_echo.sv =====
// Echo width counter with running divide by ticks per centimeter.
module uer_echo (
  input  logic                          clk,
  input  logic                          rst_n,
  input  uer_pkg::echo_ctl_t            ctl,
  input  logic [uer_pkg::DIV_W-1:0]     us_per_cm,
  output logic [uer_pkg::PULSE_W-1:0]   width,
  output logic [uer_pkg::DIST_W-1:0]    distance
);
  import uer_pkg::*;

  logic [PULSE_W-1:0] width_r, width_nxt, width_base;
  logic [DIV_W-1:0]   sub_r, sub_nxt, sub_base, sub_inc;
  logic [DIST_W-1:0]  dist_r, dist_nxt, dist_base;

  always_comb begin
    width_base = ctl.clear ? '0 : width_r;
    sub_base   = ctl.clear ? '0 : sub_r;
    dist_base  = ctl.clear ? '0 : dist_r;
    sub_inc    = sub_base + 1'b1;
    width_nxt  = width_base;
    sub_nxt    = sub_base;
    dist_nxt   = dist_base;
    // Stop counting once the width saturates.
    if (ctl.count && width_base != PULSE_MAX) begin
      width_nxt = width_base + 1'b1;
      sub_nxt   = sub_inc;
      if (sub_inc == us_per_cm) begin
        sub_nxt = '0;
        if (dist_base != DIST_MAX) begin
          dist_nxt = dist_base + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= '0;
      sub_r   <= '0;
      dist_r  <= '0;
    end else begin
      width_r <= width_nxt;
      sub_r   <= sub_nxt;
      dist_r  <= dist_nxt;
    end
  end

  assign width    = width_r;
  assign distance = dist_r;

endmodule

// ===== sv/uer_ctrl.sv =====
// Measurement sequencer: trigger pulse, readback checks and echo watchdog.
module uer_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic                          start_req,
  input  logic                          echo_level,
  input  logic                          trig_sense,
  input  logic [uer_pkg::TRIG_W-1:0]    trigger_us,
  input  logic [uer_pkg::TOUT_W-1:0]    timeout_us,
  input  logic [uer_pkg::DIST_W-1:0]    max_distance_cm,
  input  logic [uer_pkg::PULSE_W-1:0]   width,
  input  logic [uer_pkg::DIST_W-1:0]    distance,
  output uer_pkg::echo_ctl_t            echo_ctl,
  output uer_pkg::res_t                 res
);
  import uer_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HIGH,
    PH_RELEASE,
    PH_RISE,
    PH_FALL
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [TRIG_W-1:0]   trig_cnt_r, trig_cnt_nxt, trig_len, trig_inc;
  logic [TOUT_W-1:0]   wd_r, wd_nxt, wd_inc;
  logic                wd_expired;

  assign trig_len   = (trigger_us == '0) ? TRIG_W'(1) : trigger_us;
  assign trig_inc   = trig_cnt_r + 1'b1;
  assign wd_expired = (wd_r >= timeout_us);
  assign wd_inc     = (wd_r != PULSE_MAX) ? wd_r + 1'b1 : wd_r;

  always_comb begin
    phase_nxt    = phase_r;
    trig_cnt_nxt = trig_cnt_r;
    wd_nxt       = wd_r;
    echo_ctl     = '0;
    res          = '0;
    case (phase_r)
      PH_IDLE: begin
        if (start_req) begin
          if (trig_sense) begin
            res.done   = 1'b1;
            res.status = ST_TRIG_STUCK;
          end else begin
            trig_cnt_nxt = '0;
            phase_nxt    = PH_HIGH;
          end
        end
      end
      PH_HIGH: begin
        res.trig_drive = 1'b1;
        if (trig_cnt_r == '0 && !trig_sense) begin
          res.done   = 1'b1;
          res.status = ST_TRIG_NOHI;
          phase_nxt  = PH_IDLE;
        end else begin
          trig_cnt_nxt = trig_inc;
          if (trig_inc >= trig_len) begin
            phase_nxt = PH_RELEASE;
          end
        end
      end
      PH_RELEASE: begin
        if (trig_sense) begin
          res.done   = 1'b1;
          res.status = ST_TRIG_NOLO;
          phase_nxt  = PH_IDLE;
        end else if (echo_level) begin
          res.done   = 1'b1;
          res.status = ST_ECHO_EARLY;
          phase_nxt  = PH_IDLE;
        end else begin
          wd_nxt    = '0;
          phase_nxt = PH_RISE;
        end
      end
      PH_RISE: begin
        if (echo_level) begin
          echo_ctl.clear = 1'b1;
          echo_ctl.count = 1'b1;
          if (!wd_expired) begin
            wd_nxt = wd_inc;
          end
          phase_nxt = PH_FALL;
        end else if (wd_expired) begin
          res.done   = 1'b1;
          res.status = ST_NO_RISE;
          phase_nxt  = PH_IDLE;
        end else begin
          wd_nxt = wd_inc;
        end
      end
      PH_FALL: begin
        if (echo_level) begin
          if (wd_expired) begin
            res.done   = 1'b1;
            res.status = ST_NO_FALL;
            phase_nxt  = PH_IDLE;
          end else begin
            wd_nxt         = wd_inc;
            echo_ctl.count = 1'b1;
          end
        end else begin
          res.done        = 1'b1;
          res.pulse_us    = width;
          res.distance_cm = distance;
          res.status      = (distance > max_distance_cm) ? ST_TOO_FAR : ST_OK;
          phase_nxt       = PH_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
    res.busy = (phase_nxt != PH_IDLE);
    if (!step) begin
      echo_ctl = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      trig_cnt_r <= '0;
      wd_r       <= '0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      trig_cnt_r <= trig_cnt_nxt;
      wd_r       <= wd_nxt;
    end
  end

endmodule

// ===== sv/ultrasonic_echo_ranger_core.sv =====
// Top level of the ultrasonic echo ranger: input and result registers, config, sequencer.
//
//   channel | direction | handshake         | payload
//   --------+-----------+-------------------+-----------------------------------------
//   in_     | in        | in_valid/in_stall | start_req, echo_level, trig_sense
//   out_    | out       | out_valid/out_stall| trig_drive, busy_res, done_res, status,
//           |           |                   | pulse_us, distance_cm
//   cfg_    | in        | cfg_wr_en         | cfg_index, cfg_data
//
// One tick is taken per clock cycle while in_stall is low; its result passes
// through the input register, then the result register, set by the single
// sequencer step between them.
// Reset is synchronous and active low; it returns the sequencer to idle and
// loads the register defaults.
// A stall on the result side holds the result register; the input register
// still takes one more tick, then in_stall rises until the result moves.
module ultrasonic_echo_ranger_core (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_start_req,
  input  logic                          in_echo_level,
  input  logic                          in_trig_sense,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_trig_drive,
  output logic                          out_busy_res,
  output logic                          out_done_res,
  output logic [2:0]                    out_status,
  output logic [uer_pkg::PULSE_W-1:0]   out_pulse_us,
  output logic [uer_pkg::DIST_W-1:0]    out_distance_cm,
  // configuration port
  input  logic                          cfg_wr_en,
  input  logic [uer_pkg::IDX_W-1:0]     cfg_index,
  input  logic [uer_pkg::CFG_W-1:0]     cfg_data
);
  import uer_pkg::*;

  // Configuration registers.
  logic [TRIG_W-1:0] trigger_us_r;
  logic [TOUT_W-1:0] timeout_us_r;
  logic [DIV_W-1:0]  us_per_cm_r;
  logic [DIST_W-1:0] max_dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trigger_us_r <= TRIGGER_US_RST;
      timeout_us_r <= TIMEOUT_US_RST;
      us_per_cm_r  <= US_PER_CM_RST;
      max_dist_r   <= MAX_DISTANCE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_TRIGGER_US:   trigger_us_r <= cfg_data[TRIG_W-1:0];
        REG_TIMEOUT_US:   timeout_us_r <= cfg_data[TOUT_W-1:0];
        REG_US_PER_CM:    us_per_cm_r  <= cfg_data[DIV_W-1:0];
        REG_MAX_DISTANCE: max_dist_r   <= cfg_data[DIST_W-1:0];
        default: begin
          // indexes past the list are dropped
        end
      endcase
    end
  end

  // Input register: one tick of pin samples.
  logic in_vld_r;
  logic start_r, echo_r, sense_r;
  logic in_xfer, advance;

  // Advance the held tick whenever the result register is free or draining.
  assign advance  = in_vld_r && (!out_valid || !out_stall);
  assign in_stall = in_vld_r && !advance;
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_xfer) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      start_r <= in_start_req;
      echo_r  <= in_echo_level;
      sense_r <= in_trig_sense;
    end
  end

  // Sequencer and echo counter; both update only when a tick advances.
  echo_ctl_t          echo_ctl;
  res_t               res;
  logic [PULSE_W-1:0] echo_width;
  logic [DIST_W-1:0]  echo_dist;

  uer_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (advance),
    .start_req       (start_r),
    .echo_level      (echo_r),
    .trig_sense      (sense_r),
    .trigger_us      (trigger_us_r),
    .timeout_us      (timeout_us_r),
    .max_distance_cm (max_dist_r),
    .width           (echo_width),
    .distance        (echo_dist),
    .echo_ctl        (echo_ctl),
    .res             (res)
  );

  uer_echo u_echo (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (echo_ctl),
    .us_per_cm (us_per_cm_r),
    .width     (echo_width),
    .distance  (echo_dist)
  );

  // Result register.
  logic out_vld_r;
  res_t res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_trig_drive  = res_r.trig_drive;
  assign out_busy_res    = res_r.busy;
  assign out_done_res    = res_r.done;
  assign out_status      = res_r.status;
  assign out_pulse_us    = res_r.pulse_us;
  assign out_distance_cm = res_r.distance_cm;

  // A finished measurement never reports busy.
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_busy_res)
    else $error("done result reports busy");

  // Failures carry no width or distance.
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res && out_status != ST_OK && out_status != ST_TOO_FAR
    |-> out_pulse_us == '0 && out_distance_cm == '0)
    else $error("fault result carries measurement data");

  // A result with no measurement end carries a zero status.
  a_idle_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_done_res |-> out_status == ST_OK && out_pulse_us == '0)
    else $error("non-done result carries data");

  // Stall the input only while a tick is held and cannot advance.
  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_vld_r && out_valid && out_stall)
    else $error("input stalled without a blocked result");

endmodule
